[hdl/shdc_pkg.sv]
// Shared types and constants for the sample history drift checker.
// Used by shdc_cell, shdc_scan and sample_history_drift_check; depends on nothing.
`default_nettype none

package shdc_pkg;

    // Field widths of the stream payloads
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 16;
    localparam int SUM_OUT_W  = 20;
    localparam int SLOT_OUT_W = 4;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - SUM_OUT_W - 1 - SLOT_OUT_W;

    // Threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = 16'd50;

    // Input kinds carried on s_tuser
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    // Status from the scan unit back to the sequencer
    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

`default_nettype wire

[hdl/sample_history_drift_check.sv]
// Top level of the sample history drift checker: ring of cells, scan unit, sequencer.
// Depends on shdc_pkg, shdc_cell and shdc_scan.
//
// Usage:
//   Input stream s_*: s_tuser is the mode (0 record, 1 query), s_tdata[15:0] the sample.
//   Output stream m_*: one result per query with the window sum, drift flag and slot.
//   Config: cfg_wr_en writes cfg_wr_data into the drift threshold (reset value 50);
//   the user must write it only while no query is in flight; the block does not enforce this.
//   A record transfer shifts the ring by one cell, the new sample enters at the tail
//   and the running sum is updated; it gives no result.
//   A query rotates the ring once through all HISTORY_LEN cells, testing the head cell
//   each cycle; the sequencer then passes through ST_FINISH, which loads the result
//   into the output register, and returns to ST_IDLE, where the next item is taken.
//   The rotation through the chain of cells sets the length of the scan.
//   Records may follow each other in consecutive cycles.
//   If the receiver stalls, the result waits in the output register while further
//   records are taken; a second query completes its scan and then holds until the
//   output register is free.
//   Reset clears all cells, the running sum and the write position at once.
`default_nettype none

module sample_history_drift_check #(
    parameter int HISTORY_LEN = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [shdc_pkg::SAMPLE_W-1:0] s_tdata,  // [15:0] sample
    input  wire logic                          s_tuser,  // [0] mode
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [shdc_pkg::OUT_DATA_W-1:0]    m_tdata,  // [19:0] window_sum, [20] drift_found,
                                                         // [24:21] drift_slot, [31:25] zero
    // Threshold register write
    input  wire logic                          cfg_wr_en,
    input  wire logic [shdc_pkg::THR_W-1:0]    cfg_wr_data
);

    localparam int IDX_W = $clog2(HISTORY_LEN);
    localparam int SUM_W = $clog2(HISTORY_LEN*65535+1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_LEN-1);

    shdc_pkg::state_t       state_reg, state_next;
    shdc_pkg::scan_ctrl_t   scan_ctrl;
    shdc_pkg::scan_status_t scan_status;

    logic [shdc_pkg::SAMPLE_W-1:0] cell_q [HISTORY_LEN];
    logic [shdc_pkg::SAMPLE_W-1:0] tail_in;
    logic                          shift_en;
    logic [SUM_W-1:0]              total_reg, total_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [shdc_pkg::THR_W-1:0]    thr_reg;
    logic [IDX_W-1:0]              scan_slot;
    logic                          in_xfer;
    logic                          rec_xfer;
    logic                          qry_xfer;
    logic                          out_load;
    logic                          m_valid_reg, m_valid_next;
    logic [shdc_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Take input only while idle
    assign s_tready = (state_reg == shdc_pkg::ST_IDLE);

    assign in_xfer  = s_tvalid && s_tready;
    assign rec_xfer = in_xfer && (s_tuser == shdc_pkg::MODE_RECORD);
    assign qry_xfer = in_xfer && (s_tuser == shdc_pkg::MODE_QUERY);

    // Shift the chain on a record, rotate it while scanning
    assign shift_en = rec_xfer || (state_reg == shdc_pkg::ST_SCAN);
    assign tail_in  = rec_xfer ? s_tdata : cell_q[0];

    // Chain of cells, head at cell 0 holds the slot at the write position
    for (genvar k = 0; k < HISTORY_LEN; k++)
    begin : g_cell
        if (k == HISTORY_LEN - 1)
        begin : g_tail
            shdc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d_in     (tail_in),
                .q        (cell_q[k])
            );
        end
        else
        begin : g_body
            shdc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d_in     (cell_q[k+1]),
                .q        (cell_q[k])
            );
        end
    end

    shdc_scan #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .head      (cell_q[0]),
        .total     (total_reg),
        .threshold (thr_reg),
        .start_pos (pos_reg),
        .status    (scan_status),
        .slot      (scan_slot)
    );

    // Update running sum and write position on a record
    always_comb
    begin
        total_next = total_reg;
        pos_next   = pos_reg;
        if (rec_xfer)
        begin
            total_next = total_reg - SUM_W'(cell_q[0]) + SUM_W'(s_tdata);
            pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
        end
    end

    // Sequencer: next state, scan control and output register load
    always_comb
    begin
        state_next      = state_reg;
        scan_ctrl.start = 1'b0;
        scan_ctrl.step  = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            shdc_pkg::ST_IDLE:
            begin
                scan_ctrl.start = qry_xfer;
                if (qry_xfer)
                begin
                    state_next = shdc_pkg::ST_SCAN;
                end
            end
            shdc_pkg::ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (scan_status.done)
                begin
                    state_next = shdc_pkg::ST_FINISH;
                end
            end
            shdc_pkg::ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = shdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Pack the result and manage the output register
    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_data_next  = {{shdc_pkg::OUT_PAD_W{1'b0}},
                            shdc_pkg::SLOT_OUT_W'(scan_slot),
                            scan_status.found,
                            shdc_pkg::SUM_OUT_W'(total_reg)};
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= shdc_pkg::ST_IDLE;
            total_reg   <= '0;
            pos_reg     <= '0;
            thr_reg     <= shdc_pkg::THR_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A query transfer starts a scan on the next cycle
    a_query_scan: assert property (@(posedge clk) disable iff (!rst_n)
        qry_xfer |=> (state_reg == shdc_pkg::ST_SCAN))
        else $error("query did not start a scan");

    // A record transfer advances the write position
    a_record_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rec_xfer |=> (pos_reg != $past(pos_reg)))
        else $error("record did not advance write position");

    // The running sum does not move during a scan
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shdc_pkg::ST_SCAN) |=> (total_reg == $past(total_reg)))
        else $error("running sum changed during scan");

    // A new result appears only after a finished scan
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == shdc_pkg::ST_FINISH))
        else $error("result raised outside finish");

endmodule

`default_nettype wire

[hdl/shdc_cell.sv]
// One storage cell of the sample ring: holds a sample and takes its neighbor's on shift.
// Depends on shdc_pkg for the sample width.
`default_nettype none

module shdc_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift_en,
    input  wire logic [shdc_pkg::SAMPLE_W-1:0] d_in,
    output logic      [shdc_pkg::SAMPLE_W-1:0] q
);

    logic [shdc_pkg::SAMPLE_W-1:0] data_reg;
    logic [shdc_pkg::SAMPLE_W-1:0] data_next;

    // Take the neighbor's sample on shift, else hold
    always_comb
    begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

[hdl/shdc_scan.sv]
// Drift scan unit: tests the sample at the ring head once per cycle and keeps the
// lowest deviating slot. Depends on shdc_pkg for widths and control structs.
`default_nettype none

module shdc_scan #(
    parameter int HISTORY_LEN = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire shdc_pkg::scan_ctrl_t          ctrl,
    input  wire logic [shdc_pkg::SAMPLE_W-1:0] head,
    input  wire logic [$clog2(HISTORY_LEN*65535+1)-1:0] total,
    input  wire logic [shdc_pkg::THR_W-1:0]    threshold,
    input  wire logic [$clog2(HISTORY_LEN)-1:0] start_pos,
    output shdc_pkg::scan_status_t             status,
    output logic      [$clog2(HISTORY_LEN)-1:0] slot
);

    localparam int IDX_W = $clog2(HISTORY_LEN);
    localparam int SUM_W = $clog2(HISTORY_LEN*65535+1);
    localparam logic [SUM_W-1:0] LEN_C    = SUM_W'(HISTORY_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_LEN-1);

    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             found_reg, found_next;
    logic [SUM_W-1:0] scaled;
    logic [SUM_W-1:0] limit;
    logic [SUM_W-1:0] diff;
    logic             hit;

    // Exact test |len*sample - sum| > len*threshold
    always_comb
    begin
        scaled = LEN_C * SUM_W'(head);
        limit  = LEN_C * SUM_W'(threshold);
        diff   = (scaled >= total) ? (scaled - total) : (total - scaled);
        hit    = (diff > limit);
    end

    // Advance step count and slot index; keep the lowest hit
    always_comb
    begin
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        found_next = found_reg;
        if (ctrl.start)
        begin
            cnt_next   = '0;
            idx_next   = start_pos;
            slot_next  = '0;
            found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg + 1'b1;
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            if (hit && (!found_reg || (idx_reg < slot_reg)))
            begin
                found_next = 1'b1;
                slot_next  = idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign status.done  = ctrl.step && (cnt_reg == LAST_IDX);
    assign status.found = found_reg;
    assign slot         = slot_reg;

    // A recorded slot is always inside the ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (slot_reg <= LAST_IDX))
        else $error("drift slot outside ring");

    // Start clears the found flag on the next cycle
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> !found_reg)
        else $error("found flag not cleared by start");

    // Done comes only on a scanning step
    a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (ctrl.step && !ctrl.start))
        else $error("scan done without a step");

endmodule

`default_nettype wire

[test/shdc_drift_checker.sv]
// Checker for the sample history drift checker: watches the input, result and
// threshold-write channels, predicts every query result and compares it.
// Depends on shdc_pkg.
`timescale 1ns / 1ps

module shdc_drift_checker #(
    parameter int HISTORY_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [shdc_pkg::SAMPLE_W-1:0]   s_tdata,    // [15:0] sample
    input  logic                            s_tuser,    // [0] mode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [shdc_pkg::OUT_DATA_W-1:0] m_tdata,    // [19:0] window_sum, [20] drift_found,
                                                        // [24:21] drift_slot, [31:25] zero
    input  logic                            cfg_wr_en,
    input  logic [shdc_pkg::THR_W-1:0]      cfg_wr_data,
    output int                              fail_count,
    output int                              pending_count
);

    typedef struct packed {
        logic [shdc_pkg::SUM_OUT_W-1:0]  window_sum;
        logic                            drift_found;
        logic [shdc_pkg::SLOT_OUT_W-1:0] drift_slot;
    } drift_result_t;

    // Shadow copy of the block's state
    logic [shdc_pkg::SAMPLE_W-1:0] ring_samples [HISTORY_LEN];
    logic [47:0]                   ring_total;
    int                            ring_wr_pos;
    logic [shdc_pkg::THR_W-1:0]    drift_limit;

    drift_result_t       expected_results [$];
    int                  mismatches;

    // Lowest slot farther than the threshold from the mean, scaled by the ring length
    function automatic drift_result_t predict_drift();
        drift_result_t res;
        logic [47:0]   limit;
        logic [47:0]   scaled;
        logic [47:0]   abs_gap;
        res.window_sum  = ring_total[shdc_pkg::SUM_OUT_W-1:0];
        res.drift_found = 1'b0;
        res.drift_slot  = '0;
        limit = 48'(HISTORY_LEN) * 48'(drift_limit);
        for (int i = 0; i < HISTORY_LEN; i++)
        begin
            scaled  = 48'(HISTORY_LEN) * 48'(ring_samples[i]);
            abs_gap = (scaled >= ring_total) ? scaled - ring_total : ring_total - scaled;
            if (!res.drift_found && abs_gap > limit)
            begin
                res.drift_found = 1'b1;
                res.drift_slot  = shdc_pkg::SLOT_OUT_W'(i);
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drift_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_LEN; i++)
                ring_samples[i] = '0;
            ring_total  = '0;
            ring_wr_pos = 0;
            drift_limit = shdc_pkg::THR_RESET;
            expected_results.delete();
            mismatches  = 0;
        end
        else
        begin
            // Threshold writes only happen while the block is idle
            if (cfg_wr_en)
                drift_limit = cfg_wr_data;

            // Check the result transfer against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result transfer, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("window_sum", want.window_sum, m_tdata[19:0]);
                    compare_field("drift_found", want.drift_found, m_tdata[20]);
                    compare_field("drift_slot", want.drift_slot, m_tdata[24:21]);
                    compare_field("padding", 0, m_tdata[31:25]);
                end
            end

            // Record updates the ring; query predicts one result
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == shdc_pkg::MODE_RECORD)
                begin
                    ring_total = ring_total - 48'(ring_samples[ring_wr_pos]) + 48'(s_tdata);
                    ring_samples[ring_wr_pos] = s_tdata;
                    ring_wr_pos = (ring_wr_pos == HISTORY_LEN - 1) ? 0 : ring_wr_pos + 1;
                end
                else
                    expected_results.push_back(predict_drift());
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_results.size();
    end

endmodule

[test/tb_top.sv]
// Testbench top for sample_history_drift_check: clock, reset, stimulus, idling
// and verdict. Depends on shdc_pkg, the block and shdc_drift_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int HISTORY_LEN    = 16;
    localparam int SETTLE_CYCLES  = HISTORY_LEN + 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 80;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [shdc_pkg::SAMPLE_W-1:0]   s_tdata     = '0;   // [15:0] sample
    logic                            s_tuser     = 1'b0; // [0] mode
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [shdc_pkg::OUT_DATA_W-1:0] m_tdata;            // [19:0] window_sum, [20] drift_found,
                                                         // [24:21] drift_slot, [31:25] zero
    logic                            cfg_wr_en   = 1'b0;
    logic [shdc_pkg::THR_W-1:0]      cfg_wr_data = '0;

    int                    fail_count;
    int                    pending_count;
    logic                  idle_on     = 1'b1;
    int                    sink_stall  = 0;
    int                    quiet_cycles = 0;

    sample_history_drift_check #(
        .HISTORY_LEN (HISTORY_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    shdc_drift_checker #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel in random bursts, started only while idle_on is set
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= $urandom_range(0, 11);
        end
        else
            m_tready <= 1'b1;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, with an optional idle burst ahead of it; hold valid
    // high afterwards so back-to-back items need no extra edge
    task automatic send_item(input logic mode, input logic [shdc_pkg::SAMPLE_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drain all results, let the scan settle, then write the threshold
    task automatic write_threshold(input logic [shdc_pkg::THR_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly samples clustered around a base, with occasional outliers
    function automatic logic [shdc_pkg::SAMPLE_W-1:0] pick_sample(
        input logic [shdc_pkg::SAMPLE_W-1:0] base);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'hFFFF;
        else if (pick == 1)
            return 16'h0000;
        else if (pick < 5)
            return shdc_pkg::SAMPLE_W'($urandom);
        else
            return base + shdc_pkg::SAMPLE_W'($urandom_range(0, 96))
                        - shdc_pkg::SAMPLE_W'(48);
    endfunction

    initial
    begin
        logic [shdc_pkg::THR_W-1:0]    phase_limits [6];
        logic [shdc_pkg::SAMPLE_W-1:0] base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty ring, a single maximum sample, mixed bit patterns
        send_item(shdc_pkg::MODE_QUERY, 16'h0000);
        send_item(shdc_pkg::MODE_RECORD, 16'hFFFF);
        send_item(shdc_pkg::MODE_QUERY, 16'h0000);
        send_item(shdc_pkg::MODE_RECORD, 16'h0000);
        send_item(shdc_pkg::MODE_RECORD, 16'hAAAA);
        send_item(shdc_pkg::MODE_RECORD, 16'h5555);
        send_item(shdc_pkg::MODE_QUERY, 16'hFFFF);
        // Fill every slot with the maximum: largest sum, no drift, position wraps
        repeat (HISTORY_LEN) send_item(shdc_pkg::MODE_RECORD, 16'hFFFF);
        send_item(shdc_pkg::MODE_QUERY, 16'h1234);
        // One low sample among the maximums: every slot drifts, so slot 0 is reported
        send_item(shdc_pkg::MODE_RECORD, 16'h0001);
        send_item(shdc_pkg::MODE_QUERY, 16'h0000);

        // Random phases over a spread of thresholds, extremes included
        phase_limits[0] = 16'h0000;
        phase_limits[1] = 16'hFFFF;
        phase_limits[2] = 16'h0001;
        phase_limits[3] = shdc_pkg::THR_W'($urandom_range(2, 300));
        phase_limits[4] = shdc_pkg::THR_W'($urandom_range(301, 20000));
        phase_limits[5] = shdc_pkg::THR_W'($urandom_range(10, 80));
        for (int p = 0; p < 6; p++)
        begin
            write_threshold(phase_limits[p]);
            if (p == 5)
                idle_on <= 1'b0;
            base = shdc_pkg::SAMPLE_W'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(shdc_pkg::MODE_QUERY, shdc_pkg::SAMPLE_W'($urandom));
                else
                    send_item(shdc_pkg::MODE_RECORD, pick_sample(base));
            end
        end

        // Drain and let the last scan finish
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sample_history_drift_check.f]
hdl/shdc_pkg.sv
hdl/shdc_cell.sv
hdl/shdc_scan.sv
hdl/sample_history_drift_check.sv
test/shdc_drift_checker.sv
test/tb_top.sv
